FILE: src/pal_pkg.sv
// Shared types and constants of the positional array list.
package pal_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int WORD_W        = 32;

   localparam logic [2:0] FN_APPEND    = 3'd0;
   localparam logic [2:0] FN_INSERT    = 3'd1;
   localparam logic [2:0] FN_FRONT     = 3'd2;
   localparam logic [2:0] FN_UNORDERED = 3'd3;
   localparam logic [2:0] FN_DELETE    = 3'd4;
   localparam logic [2:0] FN_READ      = 3'd5;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERFLOW = 2'd1;
   localparam logic [1:0] ST_BAD      = 2'd2;

   typedef enum logic [4:0] {
      CELL_HOLD   = 5'b00001,
      CELL_APPEND = 5'b00010,
      CELL_INSERT = 5'b00100,
      CELL_SWAP   = 5'b01000,
      CELL_DELETE = 5'b10000
   } cell_op_type;

   typedef struct packed {
      cell_op_type               op;
      logic signed [WORD_W-1:0]  value;
   } cell_cmd_type;

endpackage

FILE: src/positional_array_list.sv
// Top level of the positional array list: control and a chain of cells.
//
// Usage: a packed list of up to DEPTH signed 32-bit words with a live count.
// Request channel (req_valid / req_stall): func, value, 1-based position.
//   func: append, insert at position, insert front, unordered insert,
//   delete, read. A request is taken when req_valid is high and req_stall
//   is low.
// Response channel (rsp_valid / rsp_stall): status, count after the
//   operation, and the word read or removed (zero otherwise).
// Timing: the response is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle while req_stall is low; each cell loads
//   from the value, a neighbor or the moved word, all in the same cycle.
// Stall: while a response waits under rsp_stall, req_stall is raised and
//   the waiting response holds; a taken response frees the slot at once.
// Reset: clears the live count and the response valid; stored words are
//   not cleared and are never read before being written.
module positional_array_list #(
   parameter int DEPTH = pal_pkg::DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_func,
   input  logic signed [pal_pkg::WORD_W-1:0]  req_value,
   input  logic [CNT_W-1:0]                   req_position,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [CNT_W-1:0]                   rsp_count,
   output logic signed [pal_pkg::WORD_W-1:0]  rsp_data
);

   logic                              accept;
   pal_pkg::cell_cmd_type             cmd;
   logic [CNT_W-1:0]                  wr_pos;
   logic [CNT_W-1:0]                  live;
   logic signed [pal_pkg::WORD_W-1:0] read_word;
   logic signed [pal_pkg::WORD_W-1:0] words [DEPTH];
   logic signed [pal_pkg::WORD_W-1:0] sel_words [DEPTH];

   assign req_stall = rsp_valid && rsp_stall;
   assign accept    = req_valid && !req_stall;

   pal_ctrl #(
      .DEPTH (DEPTH),
      .CNT_W (CNT_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .func       (req_func),
      .value      (req_value),
      .position   (req_position),
      .read_word  (read_word),
      .rsp_stall  (rsp_stall),
      .cmd        (cmd),
      .wr_pos     (wr_pos),
      .live       (live),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_count  (rsp_count),
      .rsp_data   (rsp_data)
   );

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [pal_pkg::WORD_W-1:0] left_word;
      logic signed [pal_pkg::WORD_W-1:0] right_word;

      if (i == 0) begin : g_first
         assign left_word = words[i];
      end else begin : g_left
         assign left_word = words[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_word = words[i];
      end else begin : g_right
         assign right_word = words[i+1];
      end

      pal_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .wr_pos     (wr_pos),
         .live       (live),
         .left_word  (left_word),
         .right_word (right_word),
         .moved_word (read_word),
         .word       (words[i]),
         .sel_word   (sel_words[i])
      );
   end

   // one-hot select: only the addressed cell drives a nonzero word
   always_comb begin
      read_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_word = read_word | sel_words[i];
      end
   end

endmodule

FILE: src/pal_cell.sv
// One storage cell of the list: holds one word and shifts from its neighbors.
module pal_cell #(
   parameter int CNT_W = 5,
   parameter int INDEX = 0
) (
   input  logic                               clock,
   input  pal_pkg::cell_cmd_type              cmd,
   input  logic [CNT_W-1:0]                   wr_pos,
   input  logic [CNT_W-1:0]                   live,
   input  logic signed [pal_pkg::WORD_W-1:0]  left_word,
   input  logic signed [pal_pkg::WORD_W-1:0]  right_word,
   input  logic signed [pal_pkg::WORD_W-1:0]  moved_word,
   output logic signed [pal_pkg::WORD_W-1:0]  word,
   output logic signed [pal_pkg::WORD_W-1:0]  sel_word
);

   localparam logic [CNT_W-1:0] IDX = CNT_W'(INDEX);

   logic signed [pal_pkg::WORD_W-1:0] entry_ff;
   logic signed [pal_pkg::WORD_W-1:0] entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         pal_pkg::CELL_APPEND: begin
            if (live == IDX) entry_in = cmd.value;
         end
         pal_pkg::CELL_INSERT: begin
            if (wr_pos == IDX) entry_in = cmd.value;
            else if (IDX > wr_pos) entry_in = left_word;
         end
         pal_pkg::CELL_SWAP: begin
            // displaced word goes to the end
            if (wr_pos == IDX) entry_in = cmd.value;
            else if (live == IDX) entry_in = moved_word;
         end
         pal_pkg::CELL_DELETE: begin
            if (IDX >= wr_pos) entry_in = right_word;
         end
         default: entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign word     = entry_ff;
   assign sel_word = (wr_pos == IDX) ? entry_ff : '0;

endmodule

FILE: src/pal_ctrl.sv
// Request decode, range checks, live count and response register.
module pal_ctrl #(
   parameter int DEPTH = pal_pkg::DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               accept,
   input  logic [2:0]                         func,
   input  logic signed [pal_pkg::WORD_W-1:0]  value,
   input  logic [CNT_W-1:0]                   position,
   input  logic signed [pal_pkg::WORD_W-1:0]  read_word,
   input  logic                               rsp_stall,
   output pal_pkg::cell_cmd_type              cmd,
   output logic [CNT_W-1:0]                   wr_pos,
   output logic [CNT_W-1:0]                   live,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic [CNT_W-1:0]                   rsp_count,
   output logic signed [pal_pkg::WORD_W-1:0]  rsp_data
);

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [CNT_W-1:0]                  count_ff;
   logic [CNT_W-1:0]                  count_in;
   logic                              rsp_valid_ff;
   logic                              rsp_valid_in;
   logic [1:0]                        status_ff;
   logic [1:0]                        status_in;
   logic [CNT_W-1:0]                  rcount_ff;
   logic signed [pal_pkg::WORD_W-1:0] data_ff;
   logic signed [pal_pkg::WORD_W-1:0] data_in;
   logic                              full;
   logic                              ins_ok;
   logic                              live_ok;
   logic [CNT_W:0]                    count_p1;
   pal_pkg::cell_op_type              op;

   assign full     = (count_ff == FULL_CNT);
   assign count_p1 = {1'b0, count_ff} + 1'b1;
   assign ins_ok   = (position != '0) && ({1'b0, position} <= count_p1);
   assign live_ok  = (position != '0) && (position <= count_ff);

   always_comb begin
      op        = pal_pkg::CELL_HOLD;
      status_in = pal_pkg::ST_OK;
      data_in   = '0;
      wr_pos    = position - 1'b1;
      count_in  = count_ff;
      unique case (func)
         pal_pkg::FN_APPEND: begin
            if (full) status_in = pal_pkg::ST_OVERFLOW;
            else op = pal_pkg::CELL_APPEND;
         end
         pal_pkg::FN_INSERT: begin
            if (full) status_in = pal_pkg::ST_OVERFLOW;
            else if (!ins_ok) status_in = pal_pkg::ST_BAD;
            else op = pal_pkg::CELL_INSERT;
         end
         pal_pkg::FN_FRONT: begin
            wr_pos = '0;
            if (full) status_in = pal_pkg::ST_OVERFLOW;
            else op = pal_pkg::CELL_INSERT;
         end
         pal_pkg::FN_UNORDERED: begin
            if (full) status_in = pal_pkg::ST_OVERFLOW;
            else if (!ins_ok) status_in = pal_pkg::ST_BAD;
            else op = pal_pkg::CELL_SWAP;
         end
         pal_pkg::FN_DELETE: begin
            if (!live_ok) status_in = pal_pkg::ST_BAD;
            else begin
               op      = pal_pkg::CELL_DELETE;
               data_in = read_word;
            end
         end
         pal_pkg::FN_READ: begin
            if (!live_ok) status_in = pal_pkg::ST_BAD;
            else data_in = read_word;
         end
         default: status_in = pal_pkg::ST_BAD;
      endcase
      if (!accept) op = pal_pkg::CELL_HOLD;
      case (op) inside
         pal_pkg::CELL_APPEND, pal_pkg::CELL_INSERT, pal_pkg::CELL_SWAP:
            count_in = count_ff + 1'b1;
         pal_pkg::CELL_DELETE:
            count_in = count_ff - 1'b1;
         default:
            count_in = count_ff;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         rcount_ff <= count_in;
         data_ff   <= data_in;
      end
   end

   assign cmd        = '{op: op, value: value};
   assign live       = count_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = rcount_ff;
   assign rsp_data   = data_ff;

endmodule

FILE: tb/pal_list_checker.sv
`timescale 1ns / 1ps
// Request/response monitor for the positional array list: predicts each response and compares.
module pal_list_checker #(
   parameter int DEPTH = pal_pkg::DEPTH_DEFAULT,
   parameter int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_stall,
   input  logic [2:0]                         req_func,
   input  logic signed [pal_pkg::WORD_W-1:0]  req_value,
   input  logic [CNT_W-1:0]                   req_position,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  logic [1:0]                         rsp_status,
   input  logic [CNT_W-1:0]                   rsp_count,
   input  logic signed [pal_pkg::WORD_W-1:0]  rsp_data,
   input  logic                               end_check,
   output int                                 fail_count,
   output int                                 pending
);

   typedef struct packed {
      logic [1:0]                        status;
      logic [CNT_W-1:0]                  count;
      logic signed [pal_pkg::WORD_W-1:0] data;
   } list_result_type;

   logic signed [pal_pkg::WORD_W-1:0] words [DEPTH];
   int                                list_len;
   list_result_type                   expected_results [$];
   logic                              end_seen;

   initial begin
      fail_count = 0;
      pending    = 0;
      list_len   = 0;
      end_seen   = 1'b0;
   end

   task automatic report_mismatch(input string msg);
      $display("%0t mismatch: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic list_result_type apply_list_op(input logic [2:0] func,
         input logic signed [pal_pkg::WORD_W-1:0] value, input logic [CNT_W-1:0] position);
      list_result_type res;
      logic            full;
      logic            ins_ok;
      logic            live_ok;
      int              p;
      int              i;
      p       = position;
      full    = (list_len >= DEPTH);
      ins_ok  = (p >= 1) && (p <= list_len + 1);
      live_ok = (p >= 1) && (p <= list_len);
      res.status = pal_pkg::ST_OK;
      res.data   = '0;
      case (func)
         pal_pkg::FN_APPEND: begin
            if (full) res.status = pal_pkg::ST_OVERFLOW;
            else begin
               words[list_len] = value;
               list_len++;
            end
         end
         pal_pkg::FN_INSERT: begin
            if (full) res.status = pal_pkg::ST_OVERFLOW;
            else if (!ins_ok) res.status = pal_pkg::ST_BAD;
            else begin
               for (i = list_len; i > p - 1; i--) words[i] = words[i-1];
               words[p-1] = value;
               list_len++;
            end
         end
         pal_pkg::FN_FRONT: begin
            if (full) res.status = pal_pkg::ST_OVERFLOW;
            else begin
               for (i = list_len; i > 0; i--) words[i] = words[i-1];
               words[0] = value;
               list_len++;
            end
         end
         pal_pkg::FN_UNORDERED: begin
            if (full) res.status = pal_pkg::ST_OVERFLOW;
            else if (!ins_ok) res.status = pal_pkg::ST_BAD;
            else begin
               // displaced word moves to the tail
               words[list_len] = words[p-1];
               words[p-1]      = value;
               list_len++;
            end
         end
         pal_pkg::FN_DELETE: begin
            if (!live_ok) res.status = pal_pkg::ST_BAD;
            else begin
               res.data = words[p-1];
               for (i = p - 1; i + 1 < list_len; i++) words[i] = words[i+1];
               list_len--;
            end
         end
         pal_pkg::FN_READ: begin
            if (!live_ok) res.status = pal_pkg::ST_BAD;
            else res.data = words[p-1];
         end
         default: res.status = pal_pkg::ST_BAD;
      endcase
      res.count = CNT_W'(list_len);
      return res;
   endfunction

   always @(posedge clock) begin
      list_result_type got;
      list_result_type want;
      if (reset) begin
         list_len = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{status: rsp_status, count: rsp_count, data: rsp_data};
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf(
                  "response with no request outstanding: st %0d cnt %0d data %h",
                  got.status, got.count, got.data));
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)
                  report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
               if (got.count !== want.count)
                  report_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
               if (got.data !== want.data)
                  report_mismatch($sformatf("data got %h want %h", got.data, want.data));
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(apply_list_op(req_func, req_value, req_position));
         if (end_check && !end_seen) begin
            end_seen = 1'b1;
            while (expected_results.size() != 0) begin
               want = expected_results.pop_front();
               report_mismatch($sformatf("no response for request: st %0d cnt %0d data %h",
                  want.status, want.count, want.data));
            end
         end
      end
      pending <= expected_results.size();
   end

endmodule

FILE: tb/tb_positional_array_list.sv
`timescale 1ns / 1ps
// Testbench top for the positional array list: clock, reset, request stimulus, stalls, verdict.
module tb_positional_array_list;

   localparam int DEPTH = pal_pkg::DEPTH_DEFAULT;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [2:0] FN_RSVD_LO = 3'd6;
   localparam logic [2:0] FN_RSVD_HI = 3'd7;
   localparam int HOLD_CYCLES = 200;
   localparam int RANDOM_PER_PHASE = 475;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_stall;
   logic [2:0]                         req_func;
   logic signed [pal_pkg::WORD_W-1:0]  req_value;
   logic [CNT_W-1:0]                   req_position;
   logic                               rsp_valid;
   logic                               rsp_stall;
   logic [1:0]                         rsp_status;
   logic [CNT_W-1:0]                   rsp_count;
   logic signed [pal_pkg::WORD_W-1:0]  rsp_data;
   logic                               end_check;
   int                                 fail_count;
   int                                 pending;

   int   idle_pct;
   int   stall_pct;
   logic hold_trigger;
   int   fill_level;

   positional_array_list #(.DEPTH(DEPTH)) dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_func     (req_func),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count),
      .rsp_data     (rsp_data)
   );

   pal_list_checker #(.DEPTH(DEPTH), .CNT_W(CNT_W)) list_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb_positional_array_list NOT OK");
      $finish;
   end

   // response side: random stalls plus an occasional long hold-off
   initial begin
      logic hold_seen;
      int   hold_left;
      rsp_stall = 1'b0;
      hold_seen = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
         end
      end
   end

   function automatic logic signed [pal_pkg::WORD_W-1:0] random_word();
      case ($urandom_range(0, 15))
         0: return 32'sh8000_0000;
         1: return 32'sh7FFF_FFFF;
         2: return '0;
         3: return '1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_request(input logic [2:0] func,
         input logic signed [pal_pkg::WORD_W-1:0] value, input int position);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= func;
      req_value    <= value;
      req_position <= CNT_W'(position);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (func) inside
         pal_pkg::FN_APPEND, pal_pkg::FN_FRONT:
            if (fill_level < DEPTH) fill_level++;
         pal_pkg::FN_INSERT, pal_pkg::FN_UNORDERED:
            if (fill_level < DEPTH && position >= 1 && position <= fill_level + 1) fill_level++;
         pal_pkg::FN_DELETE:
            if (position >= 1 && position <= fill_level) fill_level--;
         default: ;
      endcase
   endtask

   task automatic send_insert();
      send_request(3'($urandom_range(pal_pkg::FN_APPEND, pal_pkg::FN_UNORDERED)),
         random_word(), $urandom_range(1, fill_level + 1));
   endtask

   task automatic send_live_op(input logic [2:0] func);
      if (fill_level > 0) send_request(func, random_word(), $urandom_range(1, fill_level));
      else send_request(func, random_word(), $urandom_range(0, 1));
   endtask

   task automatic run_random(input int n_items);
      int sent;
      int kind;
      int n;
      sent = 0;
      while (sent < n_items) begin
         kind = $urandom_range(0, 9);
         if (kind < 3) begin
            // fill up, then bang on the full list
            while (fill_level < DEPTH) begin
               send_insert();
               sent++;
            end
            n = $urandom_range(1, 4);
            repeat (n) begin
               send_request(3'($urandom_range(pal_pkg::FN_APPEND, pal_pkg::FN_UNORDERED)),
                  random_word(), $urandom_range(0, 31));
               sent++;
            end
         end else if (kind < 5) begin
            // drain to empty, then poke the empty list
            while (fill_level > 0) begin
               send_live_op(($urandom_range(0, 9) < 7) ? pal_pkg::FN_DELETE : pal_pkg::FN_READ);
               sent++;
            end
            n = $urandom_range(1, 2);
            repeat (n) begin
               send_request(3'($urandom_range(pal_pkg::FN_DELETE, pal_pkg::FN_READ)),
                  random_word(), $urandom_range(0, 31));
               sent++;
            end
         end else begin
            repeat (20) begin
               if ($urandom_range(0, 99) < 15) begin
                  send_request(3'($urandom_range(pal_pkg::FN_APPEND, FN_RSVD_HI)),
                     random_word(), $urandom_range(0, 31));
               end else if ($urandom_range(0, 1) == 0) begin
                  send_insert();
               end else begin
                  send_live_op(($urandom_range(0, 1) == 0) ? pal_pkg::FN_DELETE :
                     pal_pkg::FN_READ);
               end
               sent++;
            end
         end
      end
   endtask

   initial begin
      int wait_cycles;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_func     = pal_pkg::FN_APPEND;
      req_value    = '0;
      req_position = '0;
      end_check    = 1'b0;
      hold_trigger = 1'b0;
      idle_pct     = 0;
      stall_pct    = 0;
      fill_level   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: empty list, extremes, every operation, bad positions, unknown funcs
      send_request(pal_pkg::FN_READ,      32'sd5,          1);
      send_request(pal_pkg::FN_DELETE,    32'sd5,          1);
      send_request(pal_pkg::FN_READ,      32'sd5,          0);
      send_request(pal_pkg::FN_APPEND,    32'sh8000_0000,  0);
      send_request(pal_pkg::FN_APPEND,    32'sh7FFF_FFFF,  31);
      send_request(pal_pkg::FN_FRONT,     32'sd0,          0);
      send_request(pal_pkg::FN_INSERT,    -32'sd1,         1);
      send_request(pal_pkg::FN_INSERT,    32'sh5555_5555,  5);
      send_request(pal_pkg::FN_INSERT,    32'sd7,          0);
      send_request(pal_pkg::FN_INSERT,    32'sd7,          7);
      send_request(pal_pkg::FN_UNORDERED, 32'shAAAA_AAAA,  1);
      send_request(pal_pkg::FN_UNORDERED, 32'sh1234_5678,  7);
      send_request(pal_pkg::FN_UNORDERED, 32'sd9,          31);
      send_request(pal_pkg::FN_READ,      32'sd0,          1);
      send_request(pal_pkg::FN_READ,      32'sd0,          7);
      send_request(pal_pkg::FN_READ,      32'sd0,          8);
      send_request(pal_pkg::FN_DELETE,    32'sd0,          4);
      send_request(pal_pkg::FN_DELETE,    32'sd0,          6);
      send_request(FN_RSVD_LO,            32'sd1,          1);
      send_request(FN_RSVD_HI,            '1,              31);
      send_request(pal_pkg::FN_DELETE,    32'sd0,          1);

      hold_trigger <= ~hold_trigger;
      run_random(RANDOM_PER_PHASE);
      idle_pct = 47;
      run_random(RANDOM_PER_PHASE);
      idle_pct = 0;
      stall_pct <= 47;
      run_random(RANDOM_PER_PHASE);
      idle_pct = 27;
      stall_pct <= 27;
      hold_trigger <= ~hold_trigger;
      run_random(RANDOM_PER_PHASE);
      req_valid <= 1'b0;

      @(posedge clock);
      wait_cycles = 0;
      while (pending != 0 && wait_cycles < 2000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (4) @(posedge clock);
      end_check <= 1'b1;
      repeat (3) @(posedge clock);
      if (fail_count == 0)
         $display("tb_positional_array_list OK");
      else
         $display("tb_positional_array_list NOT OK");
      $finish;
   end

endmodule

FILE: filelist.f
src/pal_pkg.sv
src/pal_cell.sv
src/pal_ctrl.sv
src/positional_array_list.sv
tb/pal_list_checker.sv
tb/tb_positional_array_list.sv
